// File: sv/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// shared types, sizes and step tables for the chessboard distance transform
// ----------------------------------------------------------------------------
package cdt_pkg;

  // grid limits; cell addresses are {row, col}
  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 8;
  localparam int SIZE_W    = 9;
  localparam int CELL_W    = ROW_W + COL_W;
  localparam int CELLS     = 1 << CELL_W;
  localparam int ROW_LIM   = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int COL_LIM   = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int DIST_W    = 9;
  localparam int OUT_DIST_W = 8;
  localparam int CNT_W     = 17;
  localparam int QPTR_W    = CELL_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int NB_DIRS   = 8;
  localparam int DIR_W     = 3;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_INIT,
    S_DRAIN,
    S_POP,
    S_NB,
    S_CHK,
    S_DONE
  } state_t;

  // step codes: 2'b01 forward, 2'b11 back, 2'b00 stay
  typedef logic [1:0] step_t;

  typedef struct packed {
    logic                  reached;
    logic [DIST_W-1:0]     dval;
  } dcell_t;

  typedef struct packed {
    logic [CELL_W-1:0]     loc;
    logic [DIST_W-1:0]     dval;
  } qent_t;

  typedef struct packed {
    logic [OUT_DIST_W-1:0] distance;
    logic                  reachable;
    logic [CNT_W-1:0]      uncovered_count;
    logic                  run_done;
  } result_t;

  typedef struct packed {
    logic seed_write;
    logic read_issue;
    logic push_load;
    logic push_read;
    logic push_run;
    logic run_start;
    logic init_issue;
    logic pop_issue;
    logic nb_issue;
    logic dir_step;
    logic chk_apply;
  } cmd_t;

  typedef struct packed {
    logic out_full;
    logic init_last;
    logic queue_empty;
    logic nb_inside;
    logic dir_last;
  } stat_t;

  function automatic step_t step_dr(input logic [DIR_W-1:0] dir);
    step_t s;
    unique case (dir)
      3'd0:    s = 2'b01;
      3'd1:    s = 2'b00;
      3'd2:    s = 2'b11;
      3'd3:    s = 2'b00;
      3'd4:    s = 2'b01;
      3'd5:    s = 2'b01;
      3'd6:    s = 2'b11;
      default: s = 2'b11;
    endcase
    return s;
  endfunction

  function automatic step_t step_dc(input logic [DIR_W-1:0] dir);
    step_t s;
    unique case (dir)
      3'd0:    s = 2'b00;
      3'd1:    s = 2'b01;
      3'd2:    s = 2'b00;
      3'd3:    s = 2'b11;
      3'd4:    s = 2'b01;
      3'd5:    s = 2'b11;
      3'd6:    s = 2'b01;
      default: s = 2'b11;
    endcase
    return s;
  endfunction

endpackage

// File: sv/cdt_ctrl.sv
// ----------------------------------------------------------------------------
// cdt_ctrl
// sequencer for load, run, read and no-op words; drives the datapath by commands
// ----------------------------------------------------------------------------
module cdt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     opcode,
  input  cdt_pkg::stat_t stat,
  output cdt_pkg::cmd_t  cmd
);
  import cdt_pkg::*;

  state_t  state;
  state_t  state_next;
  opcode_t op;
  logic    accept;

  assign op       = opcode_t'(opcode);
  assign in_ready = (state == S_IDLE) && !stat.out_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_LOAD: begin
              cmd.seed_write = 1'b1;
              cmd.push_load  = 1'b1;
            end
            OP_RUN: begin
              cmd.run_start = 1'b1;
              state_next    = S_INIT;
            end
            OP_READ: begin
              cmd.read_issue = 1'b1;
              state_next     = S_RD;
            end
            default: begin
              cmd.push_load = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        cmd.push_read = 1'b1;
        state_next    = S_IDLE;
      end
      S_INIT: begin
        cmd.init_issue = 1'b1;
        if (stat.init_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_POP;
      end
      S_POP: begin
        if (stat.queue_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.pop_issue = 1'b1;
          state_next    = S_NB;
        end
      end
      S_NB: begin
        if (stat.nb_inside) begin
          cmd.nb_issue = 1'b1;
          state_next   = S_CHK;
        end else if (stat.dir_last) begin
          state_next = S_POP;
        end else begin
          cmd.dir_step = 1'b1;
        end
      end
      S_CHK: begin
        cmd.chk_apply = 1'b1;
        if (stat.dir_last) begin
          state_next = S_POP;
        end else begin
          cmd.dir_step = 1'b1;
          state_next   = S_NB;
        end
      end
      S_DONE: begin
        cmd.push_run = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/cdt_dpath.sv
// ----------------------------------------------------------------------------
// cdt_dpath
// seed, distance and frontier memories, sweep and search counters, result buffer
// ----------------------------------------------------------------------------
module cdt_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  cdt_pkg::cmd_t                cmd,
  output cdt_pkg::stat_t               stat,
  input  logic [cdt_pkg::ROW_W-1:0]    row,
  input  logic [cdt_pkg::COL_W-1:0]    col,
  input  logic                         covered_bit,
  input  logic [cdt_pkg::SIZE_W-1:0]   rows_eff,
  input  logic [cdt_pkg::SIZE_W-1:0]   cols_eff,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cdt_pkg::result_t             out_res
);
  import cdt_pkg::*;

  // memories
  logic   seed_mem [CELLS];
  dcell_t dist_mem [CELLS];
  qent_t  queue_mem [CELLS];

  logic   seed_q;
  dcell_t dist_q;
  qent_t  q_q;

  // sweep and search state
  logic [ROW_W-1:0]  ir;
  logic [COL_W-1:0]  ic;
  logic              p1_valid;
  logic [CELL_W-1:0] p1_addr;
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [CNT_W-1:0]  uncovered;
  logic [DIR_W-1:0]  dir;
  logic [CELL_W-1:0] na_addr;
  logic              rd_inside;

  logic              in_grid;
  logic              last_col;
  logic [SIZE_W:0]   nr;
  logic [SIZE_W:0]   nc;
  step_t             dr;
  step_t             dc;
  logic [CELL_W-1:0] na;
  logic [DIST_W-1:0] nd;

  logic              dm_we;
  logic [CELL_W-1:0] dm_wa;
  dcell_t            dm_wd;
  logic              q_we;
  qent_t             q_wd;

  // result buffer, two words
  result_t           ob [2];
  logic              wp;
  logic              rp;
  logic [1:0]        cnt;
  logic              push;
  logic              pop;
  result_t           res_new;

  assign in_grid  = ({1'b0, row} < rows_eff) && ({1'b0, col} < cols_eff);
  assign last_col = ({1'b0, ic} == cols_eff - SIZE_W'(1));

  // neighbour coordinates; a step below zero wraps high and fails the bound
  assign dr = step_dr(dir);
  assign dc = step_dc(dir);
  assign nr = {2'b00, q_q.loc[CELL_W-1:COL_W]} + {{(SIZE_W-1){dr[1]}}, dr};
  assign nc = {2'b00, q_q.loc[COL_W-1:0]} + {{(SIZE_W-1){dc[1]}}, dc};
  assign na = {nr[ROW_W-1:0], nc[COL_W-1:0]};
  assign nd = q_q.dval + DIST_W'(1);

  assign stat.out_full    = (cnt == 2'd2);
  assign stat.init_last   = ({1'b0, ir} == rows_eff - SIZE_W'(1)) && last_col;
  assign stat.queue_empty = (head == tail);
  assign stat.nb_inside   = (nr < {1'b0, rows_eff}) && (nc < {1'b0, cols_eff});
  assign stat.dir_last    = (dir == DIR_W'(NB_DIRS - 1));

  // one write port each for distance and queue
  always_comb begin
    dm_we = 1'b0;
    dm_wa = p1_addr;
    dm_wd = '{reached: seed_q, dval: '0};
    q_we  = 1'b0;
    q_wd  = '{loc: p1_addr, dval: '0};
    if (p1_valid) begin
      dm_we = 1'b1;
      q_we  = seed_q;
    end else if (cmd.chk_apply && !dist_q.reached) begin
      dm_we = 1'b1;
      dm_wa = na_addr;
      dm_wd = '{reached: 1'b1, dval: nd};
      q_we  = 1'b1;
      q_wd  = '{loc: na_addr, dval: nd};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_write && in_grid) begin
      seed_mem[{row, col}] <= covered_bit;
    end
    if (cmd.init_issue) begin
      seed_q <= seed_mem[{ir, ic}];
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dist_mem[dm_wa] <= dm_wd;
    end
    if (cmd.nb_issue) begin
      dist_q <= dist_mem[na];
    end else if (cmd.read_issue) begin
      dist_q <= dist_mem[{row, col}];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[tail[CELL_W-1:0]] <= q_wd;
    end
    if (cmd.pop_issue) begin
      q_q <= queue_mem[head[CELL_W-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.init_issue) begin
      p1_addr <= {ir, ic};
    end
    if (cmd.nb_issue) begin
      na_addr <= na;
    end
    if (cmd.read_issue) begin
      rd_inside <= in_grid;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ir        <= '0;
      ic        <= '0;
      p1_valid  <= 1'b0;
      head      <= '0;
      tail      <= '0;
      uncovered <= '0;
      dir       <= '0;
    end else begin
      p1_valid <= cmd.init_issue;
      if (cmd.run_start) begin
        ir        <= '0;
        ic        <= '0;
        head      <= '0;
        tail      <= '0;
        uncovered <= '0;
      end else begin
        if (cmd.init_issue) begin
          if (last_col) begin
            ic <= '0;
            ir <= ir + ROW_W'(1);
          end else begin
            ic <= ic + COL_W'(1);
          end
        end
        if (q_we) begin
          tail <= tail + QPTR_W'(1);
        end
        if (p1_valid && !seed_q) begin
          uncovered <= uncovered + CNT_W'(1);
        end
        if (cmd.pop_issue) begin
          head <= head + QPTR_W'(1);
        end
      end
      if (cmd.pop_issue) begin
        dir <= '0;
      end else if (cmd.dir_step) begin
        dir <= dir + DIR_W'(1);
      end
    end
  end

  // result word
  always_comb begin
    res_new                 = '0;
    res_new.uncovered_count = uncovered;
    res_new.run_done        = cmd.push_run;
    if (cmd.push_read && rd_inside && dist_q.reached) begin
      res_new.reachable = 1'b1;
      res_new.distance  = dist_q.dval[OUT_DIST_W-1:0];
    end
  end

  assign push      = cmd.push_load || cmd.push_read || cmd.push_run;
  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_res   = ob[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      ob[wp] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// File: sv/chessboard_distance_transform.sv
// ----------------------------------------------------------------------------
// chessboard_distance_transform
// binary grid distance transform: seed load, 8-neighbour breadth-first run,
// distance read-back
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             payload
//   cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//   in        in         in_valid/in_ready     opcode, row, col, covered_bit
//   out       out        out_valid/out_ready   distance, reachable,
//                                              uncovered_count, run_done
//
// load and no-op words are handled in the idle state, a read word through a
// registered distance memory read; a run sweeps the seeds over all rows*cols
// cells, then pops each queued cell and tries its eight neighbour directions,
// reading in-grid neighbours through the single distance memory read port
// reset clears only control state; the seed, distance and frontier memories
// hold whatever was last written and need no clearing pass
// a two-word result buffer lets a new word be taken while a result waits
// config writes are always taken and are meant only while the block is idle
// ----------------------------------------------------------------------------
module chessboard_distance_transform (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cdt_pkg::SIZE_W-1:0]      cfg_data,
  // input words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      opcode,
  input  logic [cdt_pkg::ROW_W-1:0]       row,
  input  logic [cdt_pkg::COL_W-1:0]       col,
  input  logic                            covered_bit,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cdt_pkg::OUT_DIST_W-1:0]  distance,
  output logic                            reachable,
  output logic [cdt_pkg::CNT_W-1:0]       uncovered_count,
  output logic                            run_done
);
  import cdt_pkg::*;

  logic [SIZE_W-1:0] grid_rows;
  logic [SIZE_W-1:0] grid_cols;
  logic [SIZE_W-1:0] rows_eff;
  logic [SIZE_W-1:0] cols_eff;
  cmd_t              cmd;
  stat_t             stat;
  result_t           out_res;

  // configuration registers, writable at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= SIZE_W'(256);
      grid_cols <= SIZE_W'(256);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROWS) begin
        grid_rows <= cfg_data;
      end
      if (cfg_index == CFG_COLS) begin
        grid_cols <= cfg_data;
      end
    end
  end

  // active size: zero counts as one, anything past the limit is the limit
  always_comb begin
    priority if (grid_rows == '0) begin
      rows_eff = SIZE_W'(1);
    end else if (grid_rows > SIZE_W'(ROW_LIM)) begin
      rows_eff = SIZE_W'(ROW_LIM);
    end else begin
      rows_eff = grid_rows;
    end
    priority if (grid_cols == '0) begin
      cols_eff = SIZE_W'(1);
    end else if (grid_cols > SIZE_W'(COL_LIM)) begin
      cols_eff = SIZE_W'(COL_LIM);
    end else begin
      cols_eff = grid_cols;
    end
  end

  // sequencer
  cdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .stat     (stat),
    .cmd      (cmd)
  );

  // memories, counters and result buffer
  cdt_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .row         (row),
    .col         (col),
    .covered_bit (covered_bit),
    .rows_eff    (rows_eff),
    .cols_eff    (cols_eff),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (out_res)
  );

  assign distance        = out_res.distance;
  assign reachable       = out_res.reachable;
  assign uncovered_count = out_res.uncovered_count;
  assign run_done        = out_res.run_done;

endmodule

// File: tb/sv/chessboard_distance_transform_tb.sv
// ----------------------------------------------------------------------------
// chessboard_distance_transform_tb
// self-checking bench for the grid distance transform: a short directed table, then
// phases of seed fills, runs and random load, run, read and no-op words at a range
// of grid sizes, each result checked in order against a typed value or the in-bench model
// ----------------------------------------------------------------------------
module chessboard_distance_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdt_pkg::*;

  // cycles with no handshake on any channel before the run is abandoned; the largest
  // grid run here has 256 cells, each with eight neighbour directions to visit
  localparam int QUIET_LIMIT = 50000;

  // one line of the directed table: a register write or an input word,
  // with the result typed in where it is obvious
  typedef struct {
    bit                is_cfg;
    cfg_index_t        idx;
    logic [SIZE_W-1:0] data;
    opcode_t           op;
    logic [ROW_W-1:0]  r;
    logic [COL_W-1:0]  c;
    logic              b;
    bit                typed;
    result_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [SIZE_W-1:0]     cfg_data = '0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            opcode = '0;
  logic [ROW_W-1:0]      row = '0;
  logic [COL_W-1:0]      col = '0;
  logic                  covered_bit = 1'b0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_DIST_W-1:0] distance;
  logic                  reachable;
  logic [CNT_W-1:0]      uncovered_count;
  logic                  run_done;

  // bench-side copy of the grid: sizes, seeds, reached flags and distances
  logic [SIZE_W-1:0] rows_reg = SIZE_W'(MAX_ROWS);
  logic [SIZE_W-1:0] cols_reg = SIZE_W'(MAX_COLS);
  bit                seed_mem  [CELLS];
  bit                reach_mem [CELLS];
  logic [DIST_W-1:0] dist_mem  [CELLS];
  // cells some run has written; reads inside the grid stay on these
  bit                dist_set  [CELLS];
  logic [CNT_W-1:0]  uncovered_last = '0;

  result_t           pending_results[$];
  int                fail_count = 0;
  int                words_sent = 0;
  int                quiet_cycles = 0;

  // idling percentages and the long receiver hold-off request
  int                send_gap_pct = 0;
  int                recv_gap_pct = 0;
  int                hold_len = 0;
  int                hold_tickets = 0;
  int                hold_seen = 0;
  int                hold_left = 0;

  stim_row_t         directed[$];

  chessboard_distance_transform u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .row             (row),
    .col             (col),
    .covered_bit     (covered_bit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .distance        (distance),
    .reachable       (reachable),
    .uncovered_count (uncovered_count),
    .run_done        (run_done)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // model of the block
  // ---------------------------------------------------------------------------

  // a size register of zero means one, anything past the limit means the limit
  function automatic int grid_extent(logic [SIZE_W-1:0] v, int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  // multi-source breadth-first flood with eight neighbours over the active grid
  function automatic void spread_distances(int nrows, int ncols);
    int frontier[$];
    int pos, cr, cc, dr, dc, nr, nc, ncell;
    uncovered_last = '0;
    for (cr = 0; cr < nrows; cr++) begin
      for (cc = 0; cc < ncols; cc++) begin
        pos = (cr << COL_W) + cc;
        dist_mem[pos]  = '0;
        dist_set[pos]  = 1'b1;
        reach_mem[pos] = seed_mem[pos];
        if (seed_mem[pos]) frontier.insert(frontier.size(), pos);
        else uncovered_last++;
      end
    end
    while (frontier.size() != 0) begin
      pos = frontier.pop_front();
      cr = pos >> COL_W;
      cc = pos % (1 << COL_W);
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          nr = cr + dr;
          nc = cc + dc;
          ncell = (nr << COL_W) + nc;
          // cells off the grid are simply not neighbours
          if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < nrows && nc < ncols
              && !reach_mem[ncell]) begin
            reach_mem[ncell] = 1'b1;
            dist_mem[ncell]  = dist_mem[pos] + 1'b1;
            frontier.insert(frontier.size(), ncell);
          end
        end
      end
    end
  endfunction

  // applies one accepted word to the model and returns its result word
  function automatic result_t predict_word(opcode_t op, logic [ROW_W-1:0] r,
                                           logic [COL_W-1:0] c, logic b);
    result_t res;
    int      nrows, ncols;
    bit      in_grid;
    int      addr;
    nrows   = grid_extent(rows_reg, ROW_LIM);
    ncols   = grid_extent(cols_reg, COL_LIM);
    in_grid = (int'(r) < nrows) && (int'(c) < ncols);
    addr    = int'({r, c});
    res     = '0;
    case (op)
      OP_LOAD: if (in_grid) seed_mem[addr] = b;
      OP_RUN: begin
        spread_distances(nrows, ncols);
        res.run_done = 1'b1;
      end
      OP_READ: begin
        if (in_grid && reach_mem[addr]) begin
          res.reachable = 1'b1;
          res.distance  = dist_mem[addr][OUT_DIST_W-1:0];
        end
      end
      default: ;
    endcase
    res.uncovered_count = uncovered_last;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers; every task is entered and left just after a rising edge
  // ---------------------------------------------------------------------------

  task automatic send_word(opcode_t op, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                           logic b, bit typed, result_t typed_res);
    result_t res;
    // idling schedule: sender idle 10 / receiver 74, then swapped, then none
    if (words_sent < 650) begin
      send_gap_pct = 10;
      recv_gap_pct = 74;
    end else if (words_sent < 1300) begin
      send_gap_pct = 74;
      recv_gap_pct = 10;
    end else begin
      send_gap_pct = 0;
      recv_gap_pct = 0;
    end
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    row         <= r;
    col         <= c;
    covered_bit <= b;
    // ready seen at the falling edge holds through the next rising edge
    do @(negedge clk); while (in_ready !== 1'b1);
    res = predict_word(op, r, c, b);
    pending_results.insert(pending_results.size(), typed ? typed_res : res);
    words_sent++;
    @(posedge clk);
  endtask

  // input side goes quiet until every expected word is back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_register(cfg_index_t idx, logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_ROWS) rows_reg = val;
    else cols_reg = val;
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random word over the current grid; inside reads only hit cells a run wrote
  task automatic send_random_word();
    int               pick, nrows, ncols;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    nrows = grid_extent(rows_reg, ROW_LIM);
    ncols = grid_extent(cols_reg, COL_LIM);
    pick  = $urandom_range(0, 99);
    r     = ROW_W'($urandom_range(0, 255));
    c     = COL_W'($urandom_range(0, 255));
    if (pick < 35) begin
      // mostly loads inside the grid, a few anywhere (ignored off the grid)
      if (pick < 30) begin
        r = ROW_W'($urandom_range(0, nrows - 1));
        c = COL_W'($urandom_range(0, ncols - 1));
      end
      send_word(OP_LOAD, r, c, 1'($urandom_range(0, 1)), 1'b0, '0);
    end else if (pick < 40) begin
      send_word(OP_RUN, r, c, 1'($urandom_range(0, 1)), 1'b0, '0);
    end else if (pick < 90) begin
      if (pick < 78) begin
        r = ROW_W'($urandom_range(0, nrows - 1));
        c = COL_W'($urandom_range(0, ncols - 1));
      end
      // never read a grid cell no run has touched; move it off the grid
      if (int'(r) < nrows && int'(c) < ncols && !dist_set[{r, c}]) begin
        if (ncols < COL_LIM) c = COL_W'($urandom_range(ncols, 255));
        else r = ROW_W'($urandom_range(nrows, 255));
      end
      send_word(OP_READ, r, c, 1'($urandom_range(0, 1)), 1'b0, '0);
    end else begin
      send_word(OP_NOP, r, c, 1'($urandom_range(0, 1)), 1'b0, '0);
    end
  endtask

  // one grid size: fill every cell, run once, then random words; a density of
  // zero leaves a single seed in the far corner
  task automatic run_phase(logic [SIZE_W-1:0] rows_val, logic [SIZE_W-1:0] cols_val,
                           int density, int extra);
    int nrows, ncols, r, c, k, hold_at;
    wait_all_results();
    write_register(CFG_ROWS, rows_val);
    write_register(CFG_COLS, cols_val);
    nrows = grid_extent(rows_val, ROW_LIM);
    ncols = grid_extent(cols_val, COL_LIM);
    for (r = 0; r < nrows; r++) begin
      for (c = 0; c < ncols; c++) begin
        send_word(OP_LOAD, ROW_W'(r), COL_W'(c),
                  (density == 0) ? (r == nrows - 1 && c == ncols - 1)
                                 : ($urandom_range(1, 100) <= density),
                  1'b0, '0);
      end
    end
    send_word(OP_RUN, ROW_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'b0, '0);
    hold_at = $urandom_range(0, extra - 1);
    for (k = 0; k < extra; k++) begin
      // long receiver hold-off while words keep coming, so the input stalls
      if (k == hold_at) begin
        hold_len = $urandom_range(200, 400);
        hold_tickets++;
      end
      // now and then the sender waits for everything to come back
      if ($urandom_range(0, 99) < 2) wait_all_results();
      send_random_word();
    end
  endtask

  // directed table helpers
  function automatic stim_row_t cfg_row(cfg_index_t idx, logic [SIZE_W-1:0] val);
    stim_row_t s;
    s        = '{default: '0, op: OP_NOP, idx: CFG_ROWS, want: '0};
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.data   = val;
    return s;
  endfunction

  function automatic stim_row_t word_row(opcode_t op, logic [ROW_W-1:0] r,
                                         logic [COL_W-1:0] c, logic b);
    stim_row_t s;
    s    = '{default: '0, op: OP_NOP, idx: CFG_ROWS, want: '0};
    s.op = op;
    s.r  = r;
    s.c  = c;
    s.b  = b;
    return s;
  endfunction

  function automatic stim_row_t typed_row(opcode_t op, logic [ROW_W-1:0] r,
                                          logic [COL_W-1:0] c, logic b,
                                          logic [OUT_DIST_W-1:0] d, logic rch,
                                          logic [CNT_W-1:0] cnt, logic done);
    stim_row_t s;
    s       = word_row(op, r, c, b);
    s.typed = 1'b1;
    s.want  = {d, rch, cnt, done};
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // random stalls, plus a counted hold-off whenever a new request turns up
  always @(posedge clk) begin
    if (hold_seen != hold_tickets) begin
      hold_seen <= hold_tickets;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // outputs are stable at the falling edge; a word seen here is taken next edge
  always @(negedge clk) begin
    result_t got, want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      got = {distance, reachable, uncovered_count, run_done};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result word: distance %0d reachable %0b count %0d done %0b",
                   got.distance, got.reachable, got.uncovered_count, got.run_done);
      end else begin
        want = pending_results.pop_front();
        if (got.distance !== want.distance || got.reachable !== want.reachable ||
            got.uncovered_count !== want.uncovered_count || got.run_done !== want.run_done)
        begin
          fail_count++;
          if (fail_count <= 10)
            $display({"result mismatch: distance %0d/%0d reachable %0b/%0b ",
                      "count %0d/%0d done %0b/%0b (expected/actual)"},
                     want.distance, got.distance, want.reachable, got.reachable,
                     want.uncovered_count, got.uncovered_count,
                     want.run_done, got.run_done);
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL chessboard_distance_transform");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int k;

    // reset sizes, nothing run yet: every result word reads zero
    directed.insert(directed.size(),
                    typed_row(OP_LOAD, 8'd0, 8'd0, 1'b1, 8'd0, 1'b0, 17'd0, 1'b0));
    directed.insert(directed.size(),
                    typed_row(OP_LOAD, 8'd255, 8'd255, 1'b0, 8'd0, 1'b0, 17'd0, 1'b0));
    directed.insert(directed.size(),
                    typed_row(OP_NOP, 8'd255, 8'd255, 1'b1, 8'd0, 1'b0, 17'd0, 1'b0));
    // 2 x 3 grid with no seed at all: the run finds six uncovered cells
    directed.insert(directed.size(), cfg_row(CFG_ROWS, 9'd2));
    directed.insert(directed.size(), cfg_row(CFG_COLS, 9'd3));
    directed.insert(directed.size(),
                    typed_row(OP_LOAD, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 17'd0, 1'b0));
    directed.insert(directed.size(),
                    typed_row(OP_LOAD, 8'd0, 8'd1, 1'b0, 8'd0, 1'b0, 17'd0, 1'b0));
    directed.insert(directed.size(),
                    typed_row(OP_LOAD, 8'd0, 8'd2, 1'b0, 8'd0, 1'b0, 17'd0, 1'b0));
    directed.insert(directed.size(),
                    typed_row(OP_LOAD, 8'd1, 8'd0, 1'b0, 8'd0, 1'b0, 17'd0, 1'b0));
    directed.insert(directed.size(),
                    typed_row(OP_LOAD, 8'd1, 8'd1, 1'b0, 8'd0, 1'b0, 17'd0, 1'b0));
    directed.insert(directed.size(),
                    typed_row(OP_LOAD, 8'd1, 8'd2, 1'b0, 8'd0, 1'b0, 17'd0, 1'b0));
    directed.insert(directed.size(),
                    typed_row(OP_RUN, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0, 17'd6, 1'b1));
    // unreachable cell, then reads off the grid
    directed.insert(directed.size(),
                    typed_row(OP_READ, 8'd1, 8'd2, 1'b0, 8'd0, 1'b0, 17'd6, 1'b0));
    directed.insert(directed.size(),
                    typed_row(OP_READ, 8'd2, 8'd0, 1'b0, 8'd0, 1'b0, 17'd6, 1'b0));
    directed.insert(directed.size(),
                    typed_row(OP_READ, 8'd0, 8'd255, 1'b1, 8'd0, 1'b0, 17'd6, 1'b0));
    // one seed in the corner and a fresh run
    directed.insert(directed.size(),
                    typed_row(OP_LOAD, 8'd1, 8'd2, 1'b1, 8'd0, 1'b0, 17'd6, 1'b0));
    directed.insert(directed.size(), word_row(OP_RUN, 8'd255, 8'd0, 1'b1));
    directed.insert(directed.size(), word_row(OP_READ, 8'd0, 8'd0, 1'b0));
    directed.insert(directed.size(), word_row(OP_READ, 8'd1, 8'd1, 1'b0));
    directed.insert(directed.size(), word_row(OP_READ, 8'd1, 8'd2, 1'b0));
    directed.insert(directed.size(), word_row(OP_NOP, 8'd0, 8'd0, 1'b0));
    // size zero counts as one row, oversize columns clamp to the limit;
    // reading a stale cell left by the earlier run, then one off the grid
    directed.insert(directed.size(), cfg_row(CFG_ROWS, 9'd0));
    directed.insert(directed.size(), cfg_row(CFG_COLS, 9'd511));
    directed.insert(directed.size(), word_row(OP_READ, 8'd0, 8'd1, 1'b0));
    directed.insert(directed.size(), word_row(OP_READ, 8'd1, 8'd0, 1'b1));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        wait_all_results();
        write_register(directed[i].idx, directed[i].data);
      end else begin
        send_word(directed[i].op, directed[i].r, directed[i].c, directed[i].b,
                  directed[i].typed, directed[i].want);
      end
    end

    // fixed sizes, extremes among them
    run_phase(9'd5,   9'd7,   30, 120);
    run_phase(9'd511, 9'd1,    0, 100);  // one long column, distances up to 255
    run_phase(9'd1,   9'd256, 10, 100);  // one long row
    run_phase(9'd0,   9'd0,   50,  60);  // single cell
    run_phase(9'd3,   9'd12, 100,  80);  // every cell covered
    run_phase(9'd16,  9'd16,   5, 100);
    // small random sizes
    for (k = 0; k < 6; k++)
      run_phase(SIZE_W'($urandom_range(1, 10)), SIZE_W'($urandom_range(1, 10)),
                $urandom_range(0, 60), 50);

    wait_all_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS chessboard_distance_transform");
    end else begin
      $display("FAIL chessboard_distance_transform");
    end
    $finish;
  end

endmodule

// File: files.f
sv/cdt_pkg.sv
sv/cdt_ctrl.sv
sv/cdt_dpath.sv
sv/chessboard_distance_transform.sv
tb/sv/chessboard_distance_transform_tb.sv
